[design/wbps_pkg.sv]
// Shared constants and types of the wildcard byte pattern search core.
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int REG_BYTES         = 16;
  localparam int POS_W             = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W             = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int LEN_W             = 5;
  localparam int MASK_W            = 16;
  localparam int SEL_W             = 16;
  localparam int OFFSET_W          = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int IN_DATA_W         = 8;
  localparam int OUT_DATA_W        = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_WILDCARD     = 3'd2,
    CFG_LENGTH       = 3'd3,
    CFG_SELECT       = 3'd4
  } cfg_reg_t;

  // Per-cycle command to every window cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

[design/wbps_cell.sv]
// One window cell: holds a stream byte, passes it on and checks it against its pattern byte.
`timescale 1ns / 1ps

module wbps_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  wbps_pkg::cell_ctrl_t     ctrl,
  input  logic [7:0]               byte_in,
  input  logic [7:0]               pat_byte,
  input  logic                     wild,
  input  logic                     active,
  output logic [7:0]               byte_out,
  output logic                     hit
);

  logic [7:0] window_byte;

  // The check uses the byte that this cell takes on at the current shift.
  assign hit      = !active || wild || (byte_in == pat_byte);
  assign byte_out = window_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_byte <= 8'd0;
    end else if (ctrl.clear) begin
      window_byte <= 8'd0;
    end else if (ctrl.shift) begin
      window_byte <= byte_in;
    end
  end

endmodule

[design/wbps_ctrl.sv]
// Match counting, offset tracking and the buffered result channel of the search core.
`timescale 1ns / 1ps

module wbps_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic                              last_byte,
  input  logic                              all_hit,
  input  logic [wbps_pkg::POS_W-1:0]        len_used,
  input  logic [wbps_pkg::SEL_W-1:0]        select_index,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [wbps_pkg::OFFSET_W-1:0]     out_offset
);

  localparam logic [wbps_pkg::OFFSET_W-1:0] SEEN_MAX = '1;

  logic [wbps_pkg::OFFSET_W-1:0] bytes_seen;
  logic [wbps_pkg::OFFSET_W-1:0] seen_inc;
  logic [wbps_pkg::OFFSET_W-1:0] len_ext;
  logic [wbps_pkg::SEL_W-1:0]    matches_counted;
  logic                          search_done;

  logic                          hit;
  logic                          selected;
  logic                          res_valid;
  logic                          res_found;
  logic [wbps_pkg::OFFSET_W-1:0] res_offset;

  logic                          skid_valid;
  logic                          skid_found;
  logic [wbps_pkg::OFFSET_W-1:0] skid_offset;
  logic                          out_take;

  assign seen_inc = (bytes_seen == SEEN_MAX) ? bytes_seen : bytes_seen + 1'b1;
  assign len_ext  = wbps_pkg::OFFSET_W'(len_used);
  assign hit      = accept && !search_done && (seen_inc >= len_ext) && all_hit;
  assign selected = hit && (matches_counted == select_index);

  // A found match takes precedence over the end of the image in the same item.
  always_comb begin
    res_valid  = 1'b0;
    res_found  = 1'b0;
    res_offset = '0;
    if (selected) begin
      res_valid  = 1'b1;
      res_found  = 1'b1;
      res_offset = seen_inc - len_ext;
    end else if (accept && last_byte && !search_done) begin
      res_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen      <= '0;
      matches_counted <= '0;
      search_done     <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        bytes_seen      <= '0;
        matches_counted <= '0;
        search_done     <= 1'b0;
      end else begin
        bytes_seen <= seen_inc;
        if (selected) begin
          search_done <= 1'b1;
        end else if (hit) begin
          matches_counted <= matches_counted + 1'b1;
        end
      end
    end
  end

  // Output register plus one skid entry; input stalls only when both are full.
  assign in_ready = !skid_valid;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      out_valid <= res_valid;
    end else if (out_take) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_found  <= skid_found;
        out_offset <= skid_offset;
      end else begin
        out_found  <= res_found;
        out_offset <= res_offset;
      end
    end
    if (out_valid && !out_take && res_valid) begin
      skid_found  <= res_found;
      skid_offset <= res_offset;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while the output register is empty");

  a_not_found_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_offset == '0))
    else $error("not-found result carries a nonzero offset");

  a_image_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (bytes_seen == '0 && !search_done && matches_counted == '0))
    else $error("image state not cleared after the last byte");

endmodule

[design/wildcard_byte_pattern_search_core.sv]
// Top level of the wildcard byte pattern search core: configuration, cell chain and control.
`timescale 1ns / 1ps

// Usage:
// Bytes of an image enter on the s_* stream, one item per byte, with s_tlast on the
// final byte. Each accepted byte shifts into a chain of window cells; every cell checks
// its byte against the pattern byte that its position selects, so a match ending at the
// current byte is known in the cycle the byte is accepted. Throughput is one byte per
// cycle while s_tready is high, set by this combinational window compare.
// At most one result per image leaves on the m_* stream, registered from the byte that
// causes it: the selected match with its start offset, or not-found at the last byte.
// After s_tlast the window and counters return to their reset state for the next image.
// Registers are written through cfg_we/cfg_index/cfg_data and hold across images.
// Results sit in an output register with one skid entry behind it; s_tready drops only
// when both are full, i.e. when a result is stalled and a second one has arrived.
// rst is synchronous: it clears the registers to their reset values (pattern length 1,
// all else zero), empties the window and drops m_tvalid.

module wildcard_byte_pattern_search_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Byte stream in.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [wbps_pkg::IN_DATA_W-1:0]        s_tdata,   // [7:0] data_byte
  input  logic                                  s_tlast,   // last_byte
  // Result stream out.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [wbps_pkg::OUT_DATA_W-1:0]       m_tdata    // [0] match_found, [32:1] match_offset
);

  localparam int N = wbps_pkg::MAX_PATTERN_BYTES;

  logic [63:0]                      pattern_low_bytes;
  logic [63:0]                      pattern_high_bytes;
  logic [wbps_pkg::MASK_W-1:0]      wildcard_mask;
  logic [wbps_pkg::LEN_W-1:0]       pattern_length;
  logic [wbps_pkg::SEL_W-1:0]       select_index;

  logic [2*64-1:0]                  pattern_bytes;
  logic [7:0]                       pat_arr  [N];
  logic                             wild_arr [N];
  logic [wbps_pkg::POS_W-1:0]       len_used;

  logic [7:0]                       chain    [N+1];
  logic [N-1:0]                     cell_hit;
  logic                             accept;
  wbps_pkg::cell_ctrl_t             cell_ctrl;
  logic                             out_found;
  logic [wbps_pkg::OFFSET_W-1:0]    out_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
      wildcard_mask      <= '0;
      pattern_length     <= wbps_pkg::LEN_W'(1);
      select_index       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wbps_pkg::CFG_PATTERN_LOW:  pattern_low_bytes  <= cfg_data;
        wbps_pkg::CFG_PATTERN_HIGH: pattern_high_bytes <= cfg_data;
        wbps_pkg::CFG_WILDCARD:     wildcard_mask      <= cfg_data[wbps_pkg::MASK_W-1:0];
        wbps_pkg::CFG_LENGTH:       pattern_length     <= cfg_data[wbps_pkg::LEN_W-1:0];
        wbps_pkg::CFG_SELECT:       select_index       <= cfg_data[wbps_pkg::SEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_bytes = {pattern_high_bytes, pattern_low_bytes};

  // Length zero counts as one; lengths beyond the window are cut to the window size.
  always_comb begin
    if (pattern_length == '0) begin
      len_used = wbps_pkg::POS_W'(1);
    end else if (int'(pattern_length) > N) begin
      len_used = wbps_pkg::POS_W'(N);
    end else begin
      len_used = wbps_pkg::POS_W'(pattern_length);
    end
  end

  // Pattern positions without a register compare against zero and are never wildcards.
  for (genvar j = 0; j < N; j++) begin : g_pat
    if (j < wbps_pkg::REG_BYTES) begin : g_reg
      assign pat_arr[j]  = pattern_bytes[j*8 +: 8];
      assign wild_arr[j] = wildcard_mask[j];
    end else begin : g_zero
      assign pat_arr[j]  = 8'd0;
      assign wild_arr[j] = 1'b0;
    end
  end

  assign accept          = s_tvalid && s_tready;
  assign cell_ctrl.shift = accept;
  assign cell_ctrl.clear = accept && s_tlast;
  assign chain[0]        = s_tdata[7:0];

  // Cell j checks the byte j places back; it lines up with pattern byte len-1-j.
  for (genvar j = 0; j < N; j++) begin : g_cell
    logic [wbps_pkg::POS_W-1:0] k;
    logic                       active;

    assign active = wbps_pkg::POS_W'(j) < len_used;
    assign k      = len_used - wbps_pkg::POS_W'(1) - wbps_pkg::POS_W'(j);

    wbps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .byte_in  (chain[j]),
      .pat_byte (pat_arr[k[wbps_pkg::IDX_W-1:0]]),
      .wild     (wild_arr[k[wbps_pkg::IDX_W-1:0]]),
      .active   (active),
      .byte_out (chain[j+1]),
      .hit      (cell_hit[j])
    );
  end

  wbps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .last_byte    (s_tlast),
    .all_hit      (&cell_hit),
    .len_used     (len_used),
    .select_index (select_index),
    .in_ready     (s_tready),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_found    (out_found),
    .out_offset   (out_offset)
  );

  assign m_tdata = {{(wbps_pkg::OUT_DATA_W - wbps_pkg::OFFSET_W - 1){1'b0}}, out_offset, out_found};

endmodule
